/* sv/corner_blend_poly_params_top_macros.svh */
// Assertion helpers shared by the RTL of this block.
`ifndef CORNER_BLEND_POLY_PARAMS_TOP_MACROS_SVH
`define CORNER_BLEND_POLY_PARAMS_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CBP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CBP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/cbp_pkg.sv */
package cbp_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 14;
    localparam int LIMIT_W = 14;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 14'd15000;

    localparam int ACC_W = 48;
    localparam int DEN_W = 47;
    localparam int REM_W = 71;
    localparam int Q_W   = 24;
    localparam int Q_STEPS = 24;
    localparam int H_STEPS = 7;

    localparam logic [1:0] SEG_LOW  = 2'd0;
    localparam logic [1:0] SEG_MID  = 2'd1;
    localparam logic [1:0] SEG_HIGH = 2'd2;

    localparam longint PI_Q30 = 64'd3373259426;
    localparam longint QDIV  = 64'd244140625;
    localparam longint QHALF = 64'd122070312;

    // Coefficients, x^0 first, in units of 1e-12.
    localparam longint KAP_M [8] = '{
        64'sd19791009, 64'sd666134186143, -64'sd330013481080, 64'sd130071104529,
        -64'sd42987380432, 64'sd10273903175, -64'sd1522015513, 64'sd100855961};
    localparam longint RAT0_M [8] = '{
        -64'sd752367608, 64'sd523633893607, -64'sd164560672882, 64'sd503431183942,
        -64'sd637330133243, 64'sd465475599379, -64'sd169033404870, 64'sd25479845982};
    localparam longint RAT1_M [8] = '{
        -64'sd2493089191385800, 64'sd3694113440247224, -64'sd1700347556167821,
        64'sd111110694933941, 64'sd47416625814636, 64'sd42597583124449,
        -64'sd23087564508283, 64'sd2910392915910};
    localparam longint RAT2_M [8] = '{
        64'sd2351940190204991, -64'sd920910753720125, -64'sd60322192105473,
        64'sd74733564882615, -64'sd24719347865370, 64'sd9589895635243,
        -64'sd2531916277231, 64'sd240599889194};

    typedef struct packed {
        logic [15:0]              x;
        logic [1:0]               seg;
        logic signed [ACC_W-1:0]  acc_k;
        logic signed [ACC_W-1:0]  acc_r;
    } t_hstage;

    typedef struct packed {
        logic [15:0]       kappa;
        logic [1:0]        seg;
        logic              byp;
        logic              bad;
        logic [REM_W-1:0]  rem;
        logic [DEN_W-1:0]  den;
        logic [Q_W-1:0]    q;
    } t_dstage;

    function automatic longint posq(input longint m);
        longint r;
        r = (m / QDIV) * 64'sd1048576 + ((m % QDIV) * 64'sd1048576 + QHALF) / QDIV;
        return r;
    endfunction

    // Q32 coefficient from a value in units of 1e-12.
    function automatic logic signed [ACC_W-1:0] coef48(input longint m);
        longint r;
        r = (m < 0) ? -posq(-m) : posq(m);
        return ACC_W'(r);
    endfunction

    function automatic logic signed [ACC_W-1:0] sat48(input logic signed [65:0] v);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = 66'sd140737488355327;
        lo = -66'sd140737488355328;
        if (v > hi) begin
            return hi[ACC_W-1:0];
        end else if (v < lo) begin
            return lo[ACC_W-1:0];
        end
        return v[ACC_W-1:0];
    endfunction

endpackage

/* sv/cbp_horner_cell.sv */
module cbp_horner_cell #(
    parameter int IDX = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  cbp_pkg::t_hstage i_data,
    output logic             o_valid,
    output cbp_pkg::t_hstage o_data
);

    localparam logic signed [47:0] CK  = cbp_pkg::coef48(cbp_pkg::KAP_M[IDX]);
    localparam logic signed [47:0] CR0 = cbp_pkg::coef48(cbp_pkg::RAT0_M[IDX]);
    localparam logic signed [47:0] CR1 = cbp_pkg::coef48(cbp_pkg::RAT1_M[IDX]);
    localparam logic signed [47:0] CR2 = cbp_pkg::coef48(cbp_pkg::RAT2_M[IDX]);

    logic                r_valid;
    cbp_pkg::t_hstage    r_data;
    cbp_pkg::t_hstage    n_data;
    logic signed [16:0]  w_x;
    logic signed [64:0]  w_pk;
    logic signed [64:0]  w_pr;
    logic signed [47:0]  w_cr;

    assign w_x  = $signed({1'b0, i_data.x});
    assign w_pk = i_data.acc_k * w_x;
    assign w_pr = i_data.acc_r * w_x;

    always_comb begin
        case (i_data.seg)
            cbp_pkg::SEG_LOW: w_cr = CR0;
            cbp_pkg::SEG_MID: w_cr = CR1;
            default:          w_cr = CR2;
        endcase
        n_data       = i_data;
        // floor divide by 2^14, then add the next coefficient
        n_data.acc_k = cbp_pkg::sat48(66'(w_pk >>> 14) + 66'(CK));
        n_data.acc_r = cbp_pkg::sat48(66'(w_pr >>> 14) + 66'(w_cr));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* sv/cbp_div_cell.sv */
module cbp_div_cell #(
    parameter int BIT = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  cbp_pkg::t_dstage i_data,
    output logic             o_valid,
    output cbp_pkg::t_dstage o_data
);

    logic              r_valid;
    cbp_pkg::t_dstage  r_data;
    cbp_pkg::t_dstage  n_data;
    logic [cbp_pkg::REM_W-1:0] w_dsh;

    assign w_dsh = cbp_pkg::REM_W'(i_data.den) << BIT;

    always_comb begin
        n_data = i_data;
        // restoring step: take one quotient bit
        if (!i_data.byp && (i_data.rem >= w_dsh)) begin
            n_data.rem    = i_data.rem - w_dsh;
            n_data.q[BIT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* sv/corner_blend_poly_params_top.sv */
// Corner blend parameters.
// Input stream (s side): one corner angle per beat in tdata[15:0], unsigned,
// ANGLE_FRAC_BITS fraction bits, radians; values above pi are taken as pi.
// Output stream (m side): one result beat per input beat, in order.
//   tdata: kappa Q1.15 [15:0], radius ratio Q14.10 [39:16].
//   tuser: ratio valid [0], polynomial piece [2:1].
// Configuration: i_cfg_we writes the ratio limit (whole units) from i_cfg_wdata;
// write it only while no beat is in flight.
// Pipeline: 34 register stages. Throughput: one beat per cycle while o_s_tready
// is high, set by a chain of 7 Horner multiply cells followed by 24 restoring
// divider cells, each a register stage.
// Reset empties the pipeline and sets the limit to 15000.
// When the receiver stalls, one finished beat waits in the output register and
// a second in a skid register; only then does o_s_tready drop and the whole
// chain hold.
`include "corner_blend_poly_params_top_macros.svh"

module corner_blend_poly_params_top #(
    parameter int ANGLE_FRAC_BITS = cbp_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // angle [15:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // kappa [15:0], radius_ratio [39:16]
    output logic [2:0]  o_m_tuser,   // ratio_valid [0], segment [2:1]
    input  logic        i_cfg_we,
    input  logic [13:0] i_cfg_wdata
);

    localparam int     SH     = ANGLE_FRAC_BITS - 14;
    localparam int     SH_POS = (SH > 0) ? SH : 0;
    localparam int     SH_NEG = (SH < 0) ? -SH : 0;
    localparam longint HALF   = (SH_POS > 0) ? (64'd1 << (SH_POS - 1)) : 64'd0;
    localparam longint ONE    = 64'd1 << ANGLE_FRAC_BITS;
    localparam longint PI_A   = (cbp_pkg::PI_Q30 + ((64'd1 << (30 - ANGLE_FRAC_BITS)) >> 1))
                                >> (30 - ANGLE_FRAC_BITS);
    localparam longint T24    = (12 * ONE + 4) / 5;
    localparam longint T28    = (14 * ONE + 4) / 5;

    localparam logic signed [47:0] K7  = cbp_pkg::coef48(cbp_pkg::KAP_M[7]);
    localparam logic signed [47:0] R07 = cbp_pkg::coef48(cbp_pkg::RAT0_M[7]);
    localparam logic signed [47:0] R17 = cbp_pkg::coef48(cbp_pkg::RAT1_M[7]);
    localparam logic signed [47:0] R27 = cbp_pkg::coef48(cbp_pkg::RAT2_M[7]);

    logic [13:0] r_limit;
    logic        w_en;

    cbp_pkg::t_hstage w_h  [0:cbp_pkg::H_STEPS];
    logic             w_hv [0:cbp_pkg::H_STEPS];
    cbp_pkg::t_dstage w_d  [0:cbp_pkg::Q_STEPS];
    logic             w_dv [0:cbp_pkg::Q_STEPS];

    cbp_pkg::t_hstage r_s0;
    cbp_pkg::t_hstage n_s0;
    logic             r_s0_v;
    cbp_pkg::t_dstage r_fin;
    cbp_pkg::t_dstage n_fin;
    logic             r_fin_v;

    logic [31:0] w_a;
    logic [39:0] w_xw;

    logic [39:0] r_out_data;
    logic [2:0]  r_out_user;
    logic        r_out_v;
    logic [39:0] r_skid_data;
    logic [2:0]  r_skid_user;
    logic        r_skid_v;
    logic [39:0] n_res_data;
    logic [2:0]  n_res_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= cbp_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    assign w_en       = !r_skid_v;
    assign o_s_tready = w_en;

    // saturate, align to Q14, pick the piece, load the top coefficients
    always_comb begin
        w_a = 32'(i_s_tdata);
        if (64'(w_a) > PI_A) begin
            w_a = 32'(PI_A);
        end
        if (SH >= 0) begin
            w_xw = (40'(w_a) + 40'(HALF)) >> SH_POS;
        end else begin
            w_xw = 40'(w_a) << SH_NEG;
        end
        n_s0.x     = w_xw[15:0];
        n_s0.acc_k = K7;
        if (64'(w_a) < T24) begin
            n_s0.seg   = cbp_pkg::SEG_LOW;
            n_s0.acc_r = R07;
        end else if (64'(w_a) < T28) begin
            n_s0.seg   = cbp_pkg::SEG_MID;
            n_s0.acc_r = R17;
        end else begin
            n_s0.seg   = cbp_pkg::SEG_HIGH;
            n_s0.acc_r = R27;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else if (w_en) begin
            r_s0_v <= i_s_tvalid;
        end
        if (w_en) begin
            r_s0 <= n_s0;
        end
    end

    assign w_h[0]  = r_s0;
    assign w_hv[0] = r_s0_v;

    for (genvar k = 0; k < cbp_pkg::H_STEPS; k++) begin : g_horner
        cbp_horner_cell #(
            .IDX (cbp_pkg::H_STEPS - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_hv[k]),
            .i_data  (w_h[k]),
            .o_valid (w_hv[k+1]),
            .o_data  (w_h[k+1])
        );
    end

    // round the polynomials, set up the divide for the top piece
    always_comb begin
        logic signed [47:0] pk;
        logic signed [47:0] pr;
        logic [30:0]        kq;
        logic [25:0]        rq;
        logic [52:0]        num;
        pk = w_h[cbp_pkg::H_STEPS].acc_k;
        pr = w_h[cbp_pkg::H_STEPS].acc_r;
        kq = 31'((48'(pk[46:0]) + 48'd65536) >> 17);
        rq = 26'((48'(pr[46:0]) + 48'd2097152) >> 22);
        num = (53'd1 << 52) + 53'(pr[46:1]);

        n_fin.seg = w_h[cbp_pkg::H_STEPS].seg;
        if (pk <= 48'sd0) begin
            n_fin.kappa = 16'd0;
        end else if (kq > 31'd32768) begin
            n_fin.kappa = 16'd32768;
        end else begin
            n_fin.kappa = kq[15:0];
        end
        n_fin.den = pr[46:0];
        n_fin.rem = 71'(num);
        n_fin.bad = 1'b0;
        n_fin.byp = 1'b1;
        n_fin.q   = 24'hFFFFFF;
        if (n_fin.seg != cbp_pkg::SEG_HIGH) begin
            if (pr <= 48'sd0) begin
                n_fin.q = 24'd0;
            end else if (rq <= 26'hFFFFFF) begin
                n_fin.q = rq[23:0];
            end
        end else if (pr <= 48'sd0) begin
            n_fin.bad = 1'b1;
        end else if ({pr[46:0], 24'd0} > 71'(num)) begin
            n_fin.byp = 1'b0;
            n_fin.q   = 24'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_v <= 1'b0;
        end else if (w_en) begin
            r_fin_v <= w_hv[cbp_pkg::H_STEPS];
        end
        if (w_en) begin
            r_fin <= n_fin;
        end
    end

    assign w_d[0]  = r_fin;
    assign w_dv[0] = r_fin_v;

    for (genvar k = 0; k < cbp_pkg::Q_STEPS; k++) begin : g_div
        cbp_div_cell #(
            .BIT (cbp_pkg::Q_STEPS - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_dv[k]),
            .i_data  (w_d[k]),
            .o_valid (w_dv[k+1]),
            .o_data  (w_d[k+1])
        );
    end

    always_comb begin
        logic ok;
        ok = !w_d[cbp_pkg::Q_STEPS].bad &&
             (w_d[cbp_pkg::Q_STEPS].q <= {r_limit, 10'd0});
        n_res_data = {w_d[cbp_pkg::Q_STEPS].q, w_d[cbp_pkg::Q_STEPS].kappa};
        n_res_user = {w_d[cbp_pkg::Q_STEPS].seg, ok};
    end

    // output register plus skid: the chain holds only when both are full
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (r_skid_v) begin
                if (i_m_tready) begin
                    r_out_v  <= 1'b1;
                    r_skid_v <= 1'b0;
                end
            end else if (w_dv[cbp_pkg::Q_STEPS]) begin
                if (!r_out_v || i_m_tready) begin
                    r_out_v <= 1'b1;
                end else begin
                    r_skid_v <= 1'b1;
                end
            end else if (i_m_tready) begin
                r_out_v <= 1'b0;
            end
        end
        if (r_skid_v) begin
            if (i_m_tready) begin
                r_out_data <= r_skid_data;
                r_out_user <= r_skid_user;
            end
        end else if (w_dv[cbp_pkg::Q_STEPS]) begin
            if (!r_out_v || i_m_tready) begin
                r_out_data <= n_res_data;
                r_out_user <= n_res_user;
            end else begin
                r_skid_data <= n_res_data;
                r_skid_user <= n_res_user;
            end
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    `CBP_ASSERT_IMP(a_skid_needs_out, r_skid_v, r_out_v, "skid holds a beat while output is empty")
    `CBP_ASSERT_IMP(a_valid_in_limit, o_m_tvalid && o_m_tuser[0],
        o_m_tdata[39:16] <= {r_limit, 10'd0}, "ratio flagged valid above the limit")
    `CBP_ASSERT_IMP(a_kappa_range, o_m_tvalid, o_m_tdata[15:0] <= 16'd32768,
        "kappa above one")
    `CBP_ASSERT_NXT(a_skid_drains, r_skid_v && i_m_tready, !r_skid_v && r_out_v,
        "skid did not drain into the output register")

endmodule
